// File: rtl/rne_pkg.sv
// Shared types, constants and symbol tables for the Roman numeral encoder.
`default_nettype none

package rne_pkg;

   // Field widths and limits.
   localparam int VALUE_W = 12;
   localparam int SYM_W = 3;
   localparam int DIGIT_W = 4;
   localparam int NUM_POS = 4;
   localparam int POS_W = 2;
   localparam int IDX_W = 2;
   localparam int LEN_W = 3;
   localparam int ROLE_W = 2;
   localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

   // Default depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH_DEF = 2;

   // Decimal positions.
   localparam logic [POS_W-1:0] POS_UNITS = 2'd0;
   localparam logic [POS_W-1:0] POS_TENS = 2'd1;
   localparam logic [POS_W-1:0] POS_HUNDREDS = 2'd2;
   localparam logic [POS_W-1:0] POS_THOUSANDS = 2'd3;

   // Roles of a symbol inside one digit pattern.
   localparam logic [ROLE_W-1:0] ROLE_ONE = 2'd0;
   localparam logic [ROLE_W-1:0] ROLE_FIVE = 2'd1;
   localparam logic [ROLE_W-1:0] ROLE_TEN = 2'd2;

   // Symbol codes.
   localparam logic [SYM_W-1:0] SYM_I = 3'd0;
   localparam logic [SYM_W-1:0] SYM_V = 3'd1;
   localparam logic [SYM_W-1:0] SYM_X = 3'd2;
   localparam logic [SYM_W-1:0] SYM_L = 3'd3;
   localparam logic [SYM_W-1:0] SYM_C = 3'd4;
   localparam logic [SYM_W-1:0] SYM_D = 3'd5;
   localparam logic [SYM_W-1:0] SYM_M = 3'd6;

   // One classified word: error flag and the four decimal digits, indexed by position.
   typedef struct packed {
      logic err;
      logic [NUM_POS-1:0][DIGIT_W-1:0] digits;
   } rne_entry_type;

   // Number of symbols that a digit produces.
   function automatic logic [LEN_W-1:0] pat_len(input logic [DIGIT_W-1:0] d);
      logic [LEN_W-1:0] n;
      case (d)
         4'd1, 4'd5: n = 3'd1;
         4'd2, 4'd4, 4'd6, 4'd9: n = 3'd2;
         4'd3, 4'd7: n = 3'd3;
         4'd8: n = 3'd4;
         default: n = 3'd0;
      endcase
      return n;
   endfunction

   // Role of symbol i inside the pattern of digit d.
   function automatic logic [ROLE_W-1:0] pat_role(input logic [DIGIT_W-1:0] d,
                                                  input logic [IDX_W-1:0] i);
      logic [ROLE_W-1:0] r;
      r = ROLE_ONE;
      case (d)
         4'd4: r = (i == 2'd0) ? ROLE_ONE : ROLE_FIVE;
         4'd9: r = (i == 2'd0) ? ROLE_ONE : ROLE_TEN;
         4'd5, 4'd6, 4'd7, 4'd8: r = (i == 2'd0) ? ROLE_FIVE : ROLE_ONE;
         default: r = ROLE_ONE;
      endcase
      return r;
   endfunction

   // Symbol for a role at a decimal position; thousands only ever uses M.
   function automatic logic [SYM_W-1:0] pos_sym(input logic [POS_W-1:0] p,
                                                input logic [ROLE_W-1:0] r);
      logic [SYM_W-1:0] s;
      s = SYM_M;
      case (p)
         POS_UNITS: s = (r == ROLE_ONE) ? SYM_I : (r == ROLE_FIVE) ? SYM_V : SYM_X;
         POS_TENS: s = (r == ROLE_ONE) ? SYM_X : (r == ROLE_FIVE) ? SYM_L : SYM_C;
         POS_HUNDREDS: s = (r == ROLE_ONE) ? SYM_C : (r == ROLE_FIVE) ? SYM_D : SYM_M;
         default: s = SYM_M;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// File: rtl/rne_front.sv
// Front part: accepts input words, flags invalid values and splits them into digits.
`default_nettype none

module rne_front
   import rne_pkg::*;
(
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               q_full,
   output logic               q_push,
   output rne_entry_type      q_entry
);

   logic [1:0] thou;
   logic [VALUE_W-1:0] rem_thou;
   logic [9:0] rem1;
   logic [DIGIT_W-1:0] hund;
   logic [9:0] rem_hund;
   logic [6:0] rem2;
   logic [DIGIT_W-1:0] tens;
   logic [6:0] rem_tens;
   logic [DIGIT_W-1:0] units;

   // Handshake: a word is taken whenever the queue has room.
   assign req_stall = q_full;
   assign q_push = req_valid && !q_full;

   // Digit split by parallel threshold compares and one subtract for each of thousands, hundreds and tens.
   always_comb begin
      if (req_value >= 12'd3000) begin
         thou = 2'd3;
      end else if (req_value >= 12'd2000) begin
         thou = 2'd2;
      end else if (req_value >= 12'd1000) begin
         thou = 2'd1;
      end else begin
         thou = 2'd0;
      end
      rem_thou = req_value - ({10'd0, thou} * 12'd1000);
      rem1 = rem_thou[9:0];

      hund = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (rem1 >= 10'(k * 100)) begin
            hund = 4'(k);
         end
      end
      rem_hund = rem1 - ({6'd0, hund} * 10'd100);
      rem2 = rem_hund[6:0];

      tens = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (rem2 >= 7'(k * 10)) begin
            tens = 4'(k);
         end
      end
      rem_tens = rem2 - ({3'd0, tens} * 7'd10);
      units = rem_tens[3:0];
   end

   // Classified word; digits are meaningless when the error flag is set.
   always_comb begin
      q_entry.err = (req_value == '0) || (req_value > VALUE_MAX);
      q_entry.digits[POS_THOUSANDS] = {2'b00, thou};
      q_entry.digits[POS_HUNDREDS] = hund;
      q_entry.digits[POS_TENS] = tens;
      q_entry.digits[POS_UNITS] = units;
   end

endmodule

`default_nettype wire

// File: rtl/rne_queue.sv
// Short queue of classified words between the front and back parts.
`default_nettype none

module rne_queue
   import rne_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  rne_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output rne_entry_type head_entry
);

   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

   rne_entry_type mem_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full = (count_ff == CntFull);
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// File: rtl/rne_back.sv
// Back part: walks the digits of one word and emits one symbol per cycle while rsp is not stalled.
`default_nettype none

module rne_back
   import rne_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  rne_entry_type      q_entry,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [SYM_W-1:0]   rsp_symbol,
   output logic               rsp_last,
   output logic               rsp_error
);

   logic busy_ff, busy_in;
   logic err_ff, err_in;
   logic [NUM_POS-1:0][DIGIT_W-1:0] digits_ff, digits_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0] rsp_symbol_ff, rsp_symbol_in;
   logic rsp_last_ff, rsp_last_in;
   logic rsp_error_ff, rsp_error_in;

   logic advance;
   logic [DIGIT_W-1:0] cur_digit;
   logic [LEN_W-1:0] cur_len;
   logic digit_done;
   logic any_below;
   logic [POS_W-1:0] next_pos;
   logic [POS_W-1:0] start_pos;
   logic sym_last;
   logic load;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last = rsp_last_ff;
   assign rsp_error = rsp_error_ff;

   // Step decode for the current digit and position.
   always_comb begin
      advance = busy_ff && (!rsp_valid_ff || !rsp_stall);
      cur_digit = digits_ff[pos_ff];
      cur_len = pat_len(cur_digit);
      digit_done = (({1'b0, idx_ff} + 3'd1) == cur_len);
      case (pos_ff)
         POS_THOUSANDS: begin
            any_below = (digits_ff[POS_HUNDREDS] != '0) || (digits_ff[POS_TENS] != '0)
                        || (digits_ff[POS_UNITS] != '0);
            next_pos = (digits_ff[POS_HUNDREDS] != '0) ? POS_HUNDREDS
                     : (digits_ff[POS_TENS] != '0) ? POS_TENS : POS_UNITS;
         end
         POS_HUNDREDS: begin
            any_below = (digits_ff[POS_TENS] != '0) || (digits_ff[POS_UNITS] != '0);
            next_pos = (digits_ff[POS_TENS] != '0) ? POS_TENS : POS_UNITS;
         end
         POS_TENS: begin
            any_below = (digits_ff[POS_UNITS] != '0);
            next_pos = POS_UNITS;
         end
         default: begin
            any_below = 1'b0;
            next_pos = POS_UNITS;
         end
      endcase
      sym_last = err_ff || (digit_done && !any_below);
      load = q_valid && (!busy_ff || (advance && sym_last));
      start_pos = (q_entry.digits[POS_THOUSANDS] != '0) ? POS_THOUSANDS
                : (q_entry.digits[POS_HUNDREDS] != '0) ? POS_HUNDREDS
                : (q_entry.digits[POS_TENS] != '0) ? POS_TENS : POS_UNITS;
   end

   assign q_pop = load;

   // Sequencer and output register next values.
   always_comb begin
      busy_in = busy_ff;
      err_in = err_ff;
      digits_in = digits_ff;
      pos_in = pos_ff;
      idx_in = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in = rsp_last_ff;
      rsp_error_in = rsp_error_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_symbol_in = err_ff ? SYM_I : pos_sym(pos_ff, pat_role(cur_digit, idx_ff));
         rsp_last_in = sym_last;
         rsp_error_in = err_ff;
         if (sym_last) begin
            busy_in = 1'b0;
         end else if (digit_done) begin
            pos_in = next_pos;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end

      if (load) begin
         busy_in = 1'b1;
         err_in = q_entry.err;
         digits_in = q_entry.digits;
         pos_in = start_pos;
         idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and walk registers need no reset.
   always_ff @(posedge clock) begin
      err_ff <= err_in;
      digits_ff <= digits_in;
      pos_ff <= pos_in;
      idx_ff <= idx_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff <= rsp_last_in;
      rsp_error_ff <= rsp_error_in;
   end

endmodule

`default_nettype wire

// File: rtl/binary_to_roman_numeral_encoder_unit.sv
// Top level of the Roman numeral encoder: front part, queue and back part.
//
//   Channel | Direction | Handshake         | Word
//   req     | in        | req_valid/stall   | value (12 bits)
//   rsp     | out       | rsp_valid/stall   | symbol (3 bits), last, error
//
// A word with n Roman symbols (1 to 15) yields n rsp words from the back part; an
// invalid value (zero or above 3999) yields one error word.
// The one-symbol-per-cycle sequencer in the back part sets the sustained rate while
// rsp is not stalled; the front part classifies a word in the cycle it is taken.
// Reset is synchronous and clears the queue, the sequencer and the output valid.
// A stall on rsp holds the output register; req stalls only when the queue is full.
`default_nettype none

module binary_to_roman_numeral_encoder_unit
   import rne_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [SYM_W-1:0]   rsp_symbol,
   output logic               rsp_last,
   output logic               rsp_error
);

   logic q_full;
   logic q_push;
   rne_entry_type q_push_entry;
   logic q_pop;
   logic q_head_valid;
   rne_entry_type q_head_entry;

   rne_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_value (req_value),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_push_entry)
   );

   rne_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry)
   );

   rne_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_head_valid),
      .q_entry    (q_head_entry),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last),
      .rsp_error  (rsp_error)
   );

endmodule

`default_nettype wire
